[rtl/fapsf_pkg.sv]
// Package for the first-order allpass shelf filter: item structs, config
// struct, controller states, command/status structs and saturation helpers.
// No dependencies.
`default_nettype none

package fapsf_pkg;

    // Default channel count handed to the top-level parameter
    localparam int CHANNELS_DEF = 2;

    // Configuration port geometry
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Register indexes (word address)
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_COEF  = 2'd1;
    localparam logic [1:0] REG_SHELF = 2'd2;

    // Filter modes
    localparam logic [1:0] MODE_LOWPASS    = 2'd0;
    localparam logic [1:0] MODE_HIGHPASS   = 2'd1;
    localparam logic [1:0] MODE_LOW_SHELF  = 2'd2;
    localparam logic [1:0] MODE_HIGH_SHELF = 2'd3;

    // Input item
    typedef struct packed {
        logic               channel;
        logic signed [15:0] sample_in;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               out_channel;
    } t_out_item;

    // Configuration registers
    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] coef;
        logic signed [19:0] half_gain;
    } t_cfg;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_AY,
        S_MIX,
        S_SHELF,
        S_OUT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic mul_ay;
        logic mix;
        logic shelf;
        logic load_out;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic shelf_mode;
    } t_dp_stat;

    // Saturate a 25-bit value to 18 bits signed
    function automatic logic signed [17:0] sat_18(input logic signed [24:0] v);
        logic signed [17:0] r;
        if (v > 25'sd131071) begin
            r = 18'sd131071;
        end else if (v < -25'sd131072) begin
            r = -18'sd131072;
        end else begin
            r = v[17:0];
        end
        return r;
    endfunction

    // Saturate a 25-bit value to 16 bits signed
    function automatic logic signed [15:0] sat_16(input logic signed [24:0] v);
        logic signed [15:0] r;
        if (v > 25'sd32767) begin
            r = 16'sd32767;
        end else if (v < -25'sd32768) begin
            r = -16'sd32768;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/fapsf_regs.sv]
// Configuration register file on an APB-style port.
// Depends on fapsf_pkg.
`default_nettype none

module fapsf_regs
    import fapsf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    logic [1:0] reg_idx;
    logic       wr_en;
    t_cfg       r_cfg;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Write the addressed register; ignore unmapped addresses
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MODE:  r_cfg.mode      <= pwdata[1:0];
                REG_COEF:  r_cfg.coef      <= pwdata[15:0];
                REG_SHELF: r_cfg.half_gain <= pwdata[19:0];
                default: begin
                end
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (reg_idx)
            REG_MODE:  prdata = {30'd0, r_cfg.mode};
            REG_COEF:  prdata = {16'd0, r_cfg.coef};
            REG_SHELF: prdata = {12'd0, r_cfg.half_gain};
            default:   prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/fapsf_ctrl.sv]
// Controller state machine: sequences the shared multiplier and owns the
// handshakes. Depends on fapsf_pkg.
`default_nettype none

module fapsf_ctrl
    import fapsf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // State and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_AY;
                end
            end
            S_AY: begin
                o_cmd.mul_ay = 1'b1;
                n_state      = S_MIX;
            end
            S_MIX: begin
                o_cmd.mix = 1'b1;
                n_state   = i_stat.shelf_mode ? S_SHELF : S_OUT;
            end
            S_SHELF: begin
                o_cmd.shelf = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

[rtl/fapsf_dp.sv]
// Datapath: shared multiplier, accumulator, per-channel delay registers and
// output register. Depends on fapsf_pkg.
`default_nettype none

module fapsf_dp
    import fapsf_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire t_in_item i_in,
    input  wire t_dp_cmd  i_cmd,
    output t_dp_stat      o_stat,
    output t_out_item     o_out
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Per-channel delay line
    logic signed [15:0] r_prev_x [CHANNELS];
    logic signed [17:0] r_prev_y [CHANNELS];

    // Item registers
    logic signed [15:0] r_x;
    logic               r_ch;
    logic               r_bad;
    logic signed [39:0] r_acc;
    logic signed [18:0] r_s;
    t_out_item          r_out;

    logic [CH_W-1:0]    idx;
    logic               sub_mode;
    logic               shelf_mode;
    logic signed [19:0] mul_a;
    logic signed [18:0] mul_b;
    logic signed [38:0] prod;
    logic signed [39:0] xprev_term;
    logic signed [39:0] x_term;
    logic signed [39:0] acc_sum;
    logic signed [24:0] acc_rnd;
    logic signed [17:0] y1;
    logic signed [18:0] s_next;
    logic signed [19:0] s_inc;
    logic signed [15:0] lp_out;
    logic signed [15:0] sh_out;

    assign idx        = CH_W'(r_ch);
    assign sub_mode   = (i_cfg.mode == MODE_HIGHPASS) || (i_cfg.mode == MODE_HIGH_SHELF);
    assign shelf_mode = (i_cfg.mode == MODE_LOW_SHELF) || (i_cfg.mode == MODE_HIGH_SHELF);
    assign o_stat.shelf_mode = shelf_mode;
    assign o_out      = r_out;

    // Select multiplier operands: a*x on accept, a*yprev next, h*s for shelves
    always_comb begin
        priority if (i_cmd.load_in) begin
            mul_a = 20'(i_cfg.coef);
            mul_b = 19'(i_in.sample_in);
        end else if (i_cmd.mul_ay) begin
            mul_a = 20'(i_cfg.coef);
            mul_b = 19'(r_prev_y[idx]);
        end else begin
            mul_a = i_cfg.half_gain;
            mul_b = r_s;
        end
    end

    assign prod       = mul_a * mul_b;
    assign xprev_term = {{9{r_prev_x[idx][15]}}, r_prev_x[idx], 15'd0};
    assign x_term     = {{9{r_x[15]}}, r_x, 15'd0};

    // Round Q.30 accumulator to Q.15, ties toward plus infinity
    assign acc_sum = r_acc + 40'sd16384;
    assign acc_rnd = acc_sum[39:15];
    assign y1      = sat_18(acc_rnd);
    assign s_next  = sub_mode ? (19'(r_x) - 19'(y1)) : (19'(r_x) + 19'(y1));

    // Lowpass/highpass halve with rounding; shelves round the accumulator
    assign s_inc  = 20'(r_s) + 20'sd1;
    assign lp_out = sat_16(25'(s_inc >>> 1));
    assign sh_out = sat_16(acc_rnd);

    // Item registers and accumulator
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x   <= i_in.sample_in;
            r_ch  <= i_in.channel;
            r_bad <= (32'(i_in.channel) >= CHANNELS);
            r_acc <= 40'(prod);
        end
        if (i_cmd.mul_ay) begin
            r_acc <= r_acc - 40'(prod) + xprev_term;
        end
        if (i_cmd.mix) begin
            r_s <= s_next;
        end
        if (i_cmd.shelf) begin
            r_acc <= 40'(prod) + x_term;
        end
        if (i_cmd.load_out) begin
            r_out.out_channel <= r_ch;
            if (r_bad) begin
                r_out.sample_out <= '0;
            end else begin
                r_out.sample_out <= shelf_mode ? sh_out : lp_out;
            end
        end
    end

    // Update the channel's delay registers; drop out-of-range channels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_prev_x[i] <= '0;
                r_prev_y[i] <= '0;
            end
        end else if (i_cmd.mix && !r_bad) begin
            r_prev_x[idx] <= r_x;
            r_prev_y[idx] <= y1;
        end
    end

endmodule

`default_nettype wire

[rtl/first_order_allpass_shelf_filter.sv]
// Top level of the first-order allpass shelf filter: register file,
// controller and datapath. Depends on fapsf_pkg, fapsf_regs, fapsf_ctrl, fapsf_dp.
//
//   Channel | Direction | Handshake                  | Payload
//   input   | in        | i_in_valid / o_in_ready    | i_in  (t_in_item)
//   output  | out       | o_out_valid / i_out_ready  | o_out (t_out_item)
//   config  | in/out    | psel, penable, pwrite      | paddr, pwdata, prdata
//
// One item steps through accept (a*x), a*yprev and mix, then a shelf step (h*s)
// in shelf modes only, then output, as the single shared multiplier is used in turn.
// The output register lets the next item be accepted while a result waits.
// A stalled output holds the controller in its final state until taken.
// Reset (synchronous, active low) clears the config, controller state and delay lines.
`default_nettype none

module first_order_allpass_shelf_filter
    import fapsf_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_in_item           i_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out_item               o_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    t_cfg     cfg;
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Configuration registers
    fapsf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer
    fapsf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Arithmetic and state
    fapsf_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
